FILE: sv/packed_pixel_line_drawer_macros.svh
// Assertion macros for the packed-pixel line drawer.
// Included by files that carry concurrent checks; no other dependencies.
// Simulation gets the checks; synthesis sees empty bodies.
`ifndef PACKED_PIXEL_LINE_DRAWER_MACROS_SVH
`define PACKED_PIXEL_LINE_DRAWER_MACROS_SVH

`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define PPLD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("ppld: property violated");
// Consequent must hold in the cycle after the antecedent.
`define PPLD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ppld: next-cycle property violated");
`else
`define PPLD_ASSERT(lbl, clk, rst_n, prop)
`define PPLD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: sv/ppld_pkg.sv
// Shared types, constants and helpers for the packed-pixel line drawer.
// No dependencies; used by every module of the block.
`default_nettype none

package ppld_pkg;

  localparam int unsigned CoordBits  = 10;
  localparam int unsigned ErrBits    = CoordBits + 2;
  localparam int unsigned WidthBits  = 11;
  localparam int unsigned DepthBits  = 4;
  localparam int unsigned AddrBits   = 32;
  localparam int unsigned ByteBits   = 8;
  localparam int unsigned CfgIdxBits = 2;
  // y*width + x needs one bit above the product
  localparam int unsigned LinBits    = CoordBits + WidthBits + 1;
  localparam int unsigned ScaledBits = LinBits + DepthBits;

  typedef logic [CoordBits-1:0]      coord_t;
  typedef logic signed [ErrBits-1:0] err_t;

  typedef enum logic [0:0] {
    ReqStart   = 1'b0,
    ReqAdvance = 1'b1
  } req_e;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgFbBase     = 2'd0,
    CfgFbWidth    = 2'd1,
    CfgPixelDepth = 2'd2
  } cfg_idx_e;

  localparam logic [DepthBits-1:0] Depth2 = 4'd2;
  localparam logic [DepthBits-1:0] Depth4 = 4'd4;
  localparam logic [DepthBits-1:0] Depth8 = 4'd8;

  localparam logic [AddrBits-1:0]  FbBaseRst     = 32'd0;
  localparam logic [WidthBits-1:0] FbWidthRst    = 11'd640;
  localparam logic [DepthBits-1:0] PixelDepthRst = 4'd2;

  localparam logic [ByteBits-1:0] Mask2bpp = 8'h03;
  localparam logic [ByteBits-1:0] Mask4bpp = 8'h0f;
  localparam logic [ByteBits-1:0] Mask8bpp = 8'hff;

  typedef struct packed {
    req_e   req_type;
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } ppld_in_t;

  typedef struct packed {
    logic [AddrBits-1:0] byte_address;
    logic [ByteBits-1:0] clear_mask;
    logic [ByteBits-1:0] set_bits;
    logic                last_pixel;
  } ppld_out_t;

  typedef struct packed {
    logic [AddrBits-1:0]  fb_base;
    logic [WidthBits-1:0] line_pitch;
    logic [DepthBits-1:0] pixel_depth;
  } ppld_cfg_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   last;
  } ppld_pix_t;

  function automatic logic depth_ok(logic [DepthBits-1:0] d);
    return (d == Depth2) || (d == Depth4) || (d == Depth8);
  endfunction

endpackage

`default_nettype wire

FILE: sv/packed_pixel_line_drawer.sv
// Top level of the packed-pixel line drawer: configuration registers, input
// register, line walker and address stages. Depends on ppld_pkg, ppld_walker,
// ppld_addr and packed_pixel_line_drawer_macros.svh.
//
// A start transaction latches two endpoints and gives no result; each advance
// transaction then gives one byte-write descriptor (address, clear mask, set
// bits, last flag) until the final pixel of the line. The block takes one
// transaction per cycle and gives one result per cycle while the output is not
// stalled. Advances pass through four register stages (input, walker, pixel
// offset, result). The walker's error step is two bounded adds on a word two
// bits wider than a coordinate, so each pixel follows from the previous one's
// registered line state. Configuration is read live and must only be written
// while no transaction is in flight.
`default_nettype none
`include "packed_pixel_line_drawer_macros.svh"

module packed_pixel_line_drawer (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire ppld_pkg::ppld_in_t              in_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output ppld_pkg::ppld_out_t                  out_data_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [ppld_pkg::CfgIdxBits-1:0] cfg_index_i,
  input  wire logic [ppld_pkg::AddrBits-1:0]   cfg_data_i
);
  import ppld_pkg::*;

  ppld_cfg_t cfg_q, cfg_d;
  logic      in_vld_q, in_vld_d;
  ppld_in_t  in_q;

  logic      in_load, item_stall, item_acc, line_active;
  logic      start_acc, advance_acc;
  logic      pix_valid, pix_stall;
  ppld_pix_t pix;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgFbBase:     cfg_d.fb_base     = cfg_data_i;
        CfgFbWidth:    cfg_d.line_pitch  = cfg_data_i[WidthBits-1:0];
        CfgPixelDepth: cfg_d.pixel_depth = cfg_data_i[DepthBits-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  // Input register: hold while the walker is stalled
  assign in_stall_o  = in_vld_q && item_stall;
  assign in_load     = in_valid_i && !in_stall_o;
  assign in_vld_d    = in_load || (in_vld_q && item_stall);
  assign item_acc    = in_vld_q && !item_stall;
  assign start_acc   = item_acc && (in_q.req_type == ReqStart);
  assign advance_acc = item_acc && (in_q.req_type == ReqAdvance) && line_active;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q    <= '{fb_base: FbBaseRst, line_pitch: FbWidthRst,
                    pixel_depth: PixelDepthRst};
      in_vld_q <= 1'b0;
    end else begin
      cfg_q    <= cfg_d;
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      in_q <= in_data_i;
    end
  end

  ppld_walker u_walker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pixel_depth_i (cfg_q.pixel_depth),
    .item_valid_i  (in_vld_q),
    .item_i        (in_q),
    .item_stall_o  (item_stall),
    .line_active_o (line_active),
    .pix_valid_o   (pix_valid),
    .pix_o         (pix),
    .pix_stall_i   (pix_stall)
  );

  ppld_addr u_addr (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pix_valid_i (pix_valid),
    .pix_i       (pix),
    .pix_stall_o (pix_stall),
    .out_valid_o (out_valid_o),
    .out_o       (out_data_o),
    .out_stall_i (out_stall_i)
  );

  // Input backpressure only ever comes from a stalled result
  `PPLD_ASSERT(a_stall_from_output, clk_i, rst_ni, in_stall_o |-> (out_valid_o && out_stall_i))
  // A start transaction never produces a pixel
  `PPLD_ASSERT_NEXT(a_start_no_pixel, clk_i, rst_ni, start_acc, !pix_valid)
  // An advance on an active line always produces a pixel
  `PPLD_ASSERT_NEXT(a_advance_pixel, clk_i, rst_ni, advance_acc, pix_valid)

endmodule

`default_nettype wire

FILE: sv/ppld_walker.sv
// Line walker: holds the line state, steps the error term and emits one
// pixel coordinate per advance on an active line. Depends on ppld_pkg.
`default_nettype none

module ppld_walker (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic [ppld_pkg::DepthBits-1:0] pixel_depth_i,
  input  wire logic                           item_valid_i,
  input  wire ppld_pkg::ppld_in_t             item_i,
  output logic                                item_stall_o,
  output logic                                line_active_o,
  output logic                                pix_valid_o,
  output ppld_pkg::ppld_pix_t                 pix_o,
  input  wire logic                           pix_stall_i
);
  import ppld_pkg::*;

  logic      active_q, active_d;
  logic      x_major_q, x_major_d;
  logic      x_dec_q, x_dec_d;
  logic      y_dec_q, y_dec_d;
  coord_t    org_x_q, org_x_d;
  coord_t    org_y_q, org_y_d;
  coord_t    major_last_q, major_last_d;
  coord_t    minor_ext_q, minor_ext_d;
  coord_t    idx_q, idx_d;
  coord_t    cnt_q, cnt_d;
  err_t      err_q, err_d;
  logic      pix_vld_q, pix_vld_d;
  ppld_pix_t pix_q, pix_d;

  logic   acc;
  coord_t adx, ady, maj_ext, min_ext, maj_last_new;
  logic   xmaj_new;
  coord_t px, py;
  logic   last;
  err_t   e_cur, e_step;
  logic [2:0] steps;

  function automatic coord_t move_coord(coord_t base, coord_t delta, logic down);
    return down ? (base - delta) : (base + delta);
  endfunction

  assign item_stall_o  = pix_vld_q && pix_stall_i;
  assign acc           = item_valid_i && !item_stall_o;
  assign line_active_o = active_q;
  assign pix_valid_o   = pix_vld_q;
  assign pix_o         = pix_q;

  // Endpoint setup for a start transaction
  always_comb begin
    adx = (item_i.end_x >= item_i.start_x) ? (item_i.end_x - item_i.start_x)
                                           : (item_i.start_x - item_i.end_x);
    ady = (item_i.end_y >= item_i.start_y) ? (item_i.end_y - item_i.start_y)
                                           : (item_i.start_y - item_i.end_y);
    xmaj_new     = ady < adx;
    maj_ext      = xmaj_new ? adx : ady;
    min_ext      = xmaj_new ? ady : adx;
    maj_last_new = (maj_ext != '0) ? (maj_ext - coord_t'(1)) : '0;
  end

  // Current pixel and the error step that follows it
  always_comb begin
    px   = x_major_q ? move_coord(org_x_q, idx_q, x_dec_q)
                     : move_coord(org_x_q, cnt_q, x_dec_q);
    py   = x_major_q ? move_coord(org_y_q, cnt_q, y_dec_q)
                     : move_coord(org_y_q, idx_q, y_dec_q);
    last = idx_q == major_last_q;

    // the error stays within 0..D-2, so two adds always bring it back
    e_step = err_t'({2'b00, major_last_q});
    e_cur  = err_q - err_t'({2'b00, minor_ext_q});
    steps  = '0;
    for (int k = 0; k < 2; k++) begin
      if (e_cur[ErrBits-1] && (major_last_q != '0)) begin
        e_cur = e_cur + e_step;
        steps = steps + 3'd1;
      end
    end
  end

  always_comb begin
    active_d     = active_q;
    x_major_d    = x_major_q;
    x_dec_d      = x_dec_q;
    y_dec_d      = y_dec_q;
    org_x_d      = org_x_q;
    org_y_d      = org_y_q;
    major_last_d = major_last_q;
    minor_ext_d  = minor_ext_q;
    idx_d        = idx_q;
    cnt_d        = cnt_q;
    err_d        = err_q;
    pix_vld_d    = pix_vld_q && pix_stall_i;
    pix_d        = pix_q;

    if (acc) begin
      if (item_i.req_type == ReqStart) begin
        // Replace any line in progress
        x_major_d    = xmaj_new;
        x_dec_d      = item_i.end_x < item_i.start_x;
        y_dec_d      = item_i.end_y < item_i.start_y;
        org_x_d      = item_i.start_x;
        org_y_d      = item_i.start_y;
        major_last_d = maj_last_new;
        minor_ext_d  = min_ext;
        idx_d        = '0;
        cnt_d        = '0;
        err_d        = err_t'({2'b00, maj_last_new >> 1});
        active_d     = (maj_ext > coord_t'(1)) && depth_ok(pixel_depth_i);
      end else if (active_q) begin
        pix_vld_d = 1'b1;
        pix_d     = '{x: px, y: py, last: last};
        if (last) begin
          active_d = 1'b0;
        end else begin
          err_d = e_cur;
          cnt_d = (minor_ext_q != '0) ? (cnt_q + coord_t'(steps)) : cnt_q;
          idx_d = idx_q + coord_t'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q     <= 1'b0;
      x_major_q    <= 1'b0;
      x_dec_q      <= 1'b0;
      y_dec_q      <= 1'b0;
      org_x_q      <= '0;
      org_y_q      <= '0;
      major_last_q <= '0;
      minor_ext_q  <= '0;
      idx_q        <= '0;
      cnt_q        <= '0;
      err_q        <= '0;
      pix_vld_q    <= 1'b0;
    end else begin
      active_q     <= active_d;
      x_major_q    <= x_major_d;
      x_dec_q      <= x_dec_d;
      y_dec_q      <= y_dec_d;
      org_x_q      <= org_x_d;
      org_y_q      <= org_y_d;
      major_last_q <= major_last_d;
      minor_ext_q  <= minor_ext_d;
      idx_q        <= idx_d;
      cnt_q        <= cnt_d;
      err_q        <= err_d;
      pix_vld_q    <= pix_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pix_q <= pix_d;
  end

endmodule

`default_nettype wire

FILE: sv/ppld_addr.sv
// Address and mask stages: pixel offset y*width+x, then scaling by depth,
// base add and byte masks into the result register. Depends on ppld_pkg.
`default_nettype none

module ppld_addr (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire ppld_pkg::ppld_cfg_t cfg_i,
  input  wire logic                pix_valid_i,
  input  wire ppld_pkg::ppld_pix_t pix_i,
  output logic                     pix_stall_o,
  output logic                     out_valid_o,
  output ppld_pkg::ppld_out_t      out_o,
  input  wire logic                out_stall_i
);
  import ppld_pkg::*;

  logic               s2_vld_q, s2_vld_d;
  logic [LinBits-1:0] lin_q, lin_d;
  logic [1:0]         xlo_q, xlo_d;
  logic               last_q, last_d;
  logic               out_vld_q, out_vld_d;
  ppld_out_t          out_q, out_d;

  logic                  load2, adv3;
  logic [ScaledBits-1:0] scaled;
  logic [AddrBits-1:0]   offset;
  logic [ByteBits-1:0]   clr, set;

  assign adv3        = s2_vld_q && (!out_vld_q || !out_stall_i);
  assign pix_stall_o = s2_vld_q && !adv3;
  assign load2       = pix_valid_i && !pix_stall_o;
  assign s2_vld_d    = load2 || (s2_vld_q && !adv3);
  assign out_vld_d   = adv3 || (out_vld_q && out_stall_i);
  assign out_valid_o = out_vld_q;
  assign out_o       = out_q;

  // Linear pixel index within the frame buffer
  always_comb begin
    lin_d  = LinBits'(pix_i.y) * LinBits'(cfg_i.line_pitch) + LinBits'(pix_i.x);
    xlo_d  = pix_i.x[1:0];
    last_d = pix_i.last;
  end

  always_comb begin
    scaled = ScaledBits'(lin_q) * ScaledBits'(cfg_i.pixel_depth);
    offset = AddrBits'(scaled >> 3);
    case (cfg_i.pixel_depth)
      Depth2: begin
        clr = Mask2bpp << {~xlo_q, 1'b0};
        set = '0;
      end
      Depth4: begin
        clr = Mask4bpp << {~xlo_q[0], 2'b00};
        set = '0;
      end
      Depth8: begin
        clr = Mask8bpp;
        set = Mask8bpp;
      end
      default: begin
        clr = '0;
        set = '0;
      end
    endcase
    out_d = '{byte_address: cfg_i.fb_base + offset,
              clear_mask:   clr,
              set_bits:     set,
              last_pixel:   last_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      s2_vld_q  <= s2_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load2) begin
      lin_q  <= lin_d;
      xlo_q  <= xlo_d;
      last_q <= last_d;
    end
    if (adv3) begin
      out_q <= out_d;
    end
  end

endmodule

`default_nettype wire

FILE: tb/packed_pixel_line_drawer_test.sv
// Self-checking bench for the packed-pixel line drawer: streams line starts and
// pixel advances, predicts each byte-write descriptor and compares it with the
// block's output. Depends on ppld_pkg and packed_pixel_line_drawer.
module packed_pixel_line_drawer_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ppld_pkg::*;

  localparam int unsigned CycleLimit   = 100000;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned PhaseItems   = 150;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  ppld_in_t            in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  ppld_out_t           out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  cfg_idx_e            cfg_index = CfgFbBase;
  logic [AddrBits-1:0] cfg_data = '0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned cycle_count = 0;
  int unsigned mismatches = 0;
  int unsigned reqs_taken = 0;
  int unsigned writes_checked = 0;
  int unsigned reg_writes = 0;

  ppld_in_t  line_reqs[$];
  ppld_out_t pending_writes[$];

  // shadow copies of the configuration registers
  logic [AddrBits-1:0]  fb_base_q = FbBaseRst;
  logic [WidthBits-1:0] pitch_q = FbWidthRst;
  logic [DepthBits-1:0] depth_q = PixelDepthRst;

  // shadow line walker
  logic   drawing = 1'b0;
  logic   x_major = 1'b0;
  logic   x_down = 1'b0;
  logic   y_down = 1'b0;
  coord_t org_x = '0;
  coord_t org_y = '0;
  coord_t major_last = '0;
  coord_t minor_ext = '0;
  coord_t pix_idx = '0;
  coord_t minor_cnt = '0;
  err_t   err_acc = '0;

  packed_pixel_line_drawer dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic coord_t step_coord(coord_t origin, coord_t delta, logic down);
    return down ? origin - delta : origin + delta;
  endfunction

  // Advance the shadow walker by one request; queue the byte write it causes.
  function automatic void trace_line(ppld_in_t req);
    coord_t              adx;
    coord_t              ady;
    coord_t              major;
    coord_t              px;
    coord_t              py;
    logic [AddrBits-1:0] lin;
    ppld_out_t           w;
    int                  e;
    int                  guard;
    if (req.req_type == ReqStart) begin
      adx = (req.end_x >= req.start_x) ? req.end_x - req.start_x : req.start_x - req.end_x;
      ady = (req.end_y >= req.start_y) ? req.end_y - req.start_y : req.start_y - req.end_y;
      x_down = req.end_x < req.start_x;
      y_down = req.end_y < req.start_y;
      x_major = ady < adx;
      major = x_major ? adx : ady;
      minor_ext = x_major ? ady : adx;
      org_x = req.start_x;
      org_y = req.start_y;
      major_last = (major > 0) ? major - 1'b1 : '0;
      pix_idx = '0;
      minor_cnt = '0;
      err_acc = err_t'(major_last >> 1);
      drawing = (major > 1) && (depth_q == Depth2 || depth_q == Depth4 || depth_q == Depth8);
    end else if (drawing) begin
      if (x_major) begin
        px = step_coord(org_x, pix_idx, x_down);
        py = step_coord(org_y, minor_cnt, y_down);
      end else begin
        px = step_coord(org_x, minor_cnt, x_down);
        py = step_coord(org_y, pix_idx, y_down);
      end
      lin = 32'(py) * 32'(pitch_q) + 32'(px);
      w.byte_address = fb_base_q + ((lin * 32'(depth_q)) >> 3);
      // depth is read live, so an unsupported value here gives a no-op write
      case (depth_q)
        Depth2: begin
          w.clear_mask = Mask2bpp << (2 * (3 - int'(px[1:0])));
          w.set_bits = '0;
        end
        Depth4: begin
          w.clear_mask = Mask4bpp << (4 * (1 - int'(px[0])));
          w.set_bits = '0;
        end
        Depth8: begin
          w.clear_mask = Mask8bpp;
          w.set_bits = Mask8bpp;
        end
        default: begin
          w.clear_mask = '0;
          w.set_bits = '0;
        end
      endcase
      w.last_pixel = (pix_idx == major_last);
      pending_writes.push_back(w);
      if (w.last_pixel) begin
        drawing = 1'b0;
      end else begin
        e = int'(err_acc) - int'(minor_ext);
        guard = 0;
        while (e < 0 && major_last > 0 && guard < 4) begin
          e += int'(major_last);
          if (minor_ext > 0) minor_cnt = minor_cnt + 1'b1;
          guard++;
        end
        err_acc = err_t'(e);
        pix_idx = pix_idx + 1'b1;
      end
    end
  endfunction

  // Request driver: hold a stalled transaction, otherwise maybe idle.
  always @(posedge clk) begin : feed
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        trace_line(in_data);
        reqs_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (line_reqs.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          in_data <= line_reqs.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stall.
  always @(posedge clk) begin : watch
    ppld_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_writes.size() == 0) begin
        $display("%0t: unexpected byte write, expected none, got %h", $time, out_data);
        mismatches++;
      end else begin
        want = pending_writes.pop_front();
        writes_checked++;
        if (out_data.byte_address !== want.byte_address) begin
          $display("%0t: byte_address expected %h got %h", $time,
                   want.byte_address, out_data.byte_address);
          mismatches++;
        end
        if (out_data.clear_mask !== want.clear_mask) begin
          $display("%0t: clear_mask expected %h got %h", $time,
                   want.clear_mask, out_data.clear_mask);
          mismatches++;
        end
        if (out_data.set_bits !== want.set_bits) begin
          $display("%0t: set_bits expected %h got %h", $time,
                   want.set_bits, out_data.set_bits);
          mismatches++;
        end
        if (out_data.last_pixel !== want.last_pixel) begin
          $display("%0t: last_pixel expected %b got %b", $time,
                   want.last_pixel, out_data.last_pixel);
          mismatches++;
        end
      end
    end
    out_stall <= rst_n && ($urandom_range(99, 0) < recv_stall_pct);
  end

  // Register port: drop valid once the write transaction is taken.
  always @(posedge clk) begin : reg_port
    if (rst_n && cfg_valid && cfg_ready) begin
      case (cfg_index)
        CfgFbBase:     fb_base_q = cfg_data;
        CfgFbWidth:    pitch_q = cfg_data[WidthBits-1:0];
        CfgPixelDepth: depth_q = cfg_data[DepthBits-1:0];
        default: ;
      endcase
      reg_writes++;
      cfg_valid <= 1'b0;
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timed out, %0d byte writes outstanding", $time, pending_writes.size());
      $display("** packed_pixel_line_drawer: FAILED **");
      $finish;
    end
  end

  function automatic ppld_in_t random_req();
    ppld_in_t r;
    r.req_type = req_e'($urandom_range(1, 0));
    r.start_x = coord_t'($urandom);
    r.start_y = coord_t'($urandom);
    r.end_x = coord_t'($urandom);
    r.end_y = coord_t'($urandom);
    return r;
  endfunction

  function automatic void push_start(int sx, int sy, int ex, int ey);
    ppld_in_t r;
    r.req_type = ReqStart;
    r.start_x = coord_t'(sx);
    r.start_y = coord_t'(sy);
    r.end_x = coord_t'(ex);
    r.end_y = coord_t'(ey);
    line_reqs.push_back(r);
  endfunction

  function automatic void push_advances(int unsigned n);
    ppld_in_t r;
    repeat (n) begin
      r = random_req();
      r.req_type = ReqAdvance;
      line_reqs.push_back(r);
    end
  endfunction

  // Queue a start near a random origin; return the major extent of the line.
  function automatic int unsigned push_random_start(int unsigned reach);
    int sx;
    int sy;
    int ex;
    int ey;
    int dx;
    int dy;
    sx = $urandom_range(1023, 0);
    sy = $urandom_range(1023, 0);
    dx = $urandom_range(reach, 0);
    dy = $urandom_range(reach, 0);
    case ($urandom_range(5, 0))
      0: dy = 0;
      1: dx = 0;
      2: dy = dx;
      default: ;
    endcase
    if ($urandom_range(1, 0)) dx = -dx;
    if ($urandom_range(1, 0)) dy = -dy;
    ex = sx + dx;
    ey = sy + dy;
    if (ex < 0) ex = 0;
    if (ex > 1023) ex = 1023;
    if (ey < 0) ey = 0;
    if (ey > 1023) ey = 1023;
    push_start(sx, sy, ex, ey);
    dx = (ex > sx) ? ex - sx : sx - ex;
    dy = (ey > sy) ? ey - sy : sy - ey;
    return (dx > dy) ? dx : dy;
  endfunction

  // Hold off until the block has drained every expected write.
  task automatic settle();
    do @(negedge clk);
    while (line_reqs.size() != 0 || in_valid || pending_writes.size() != 0);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [AddrBits-1:0] value);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(negedge clk);
    while (cfg_valid);
  endtask

  initial begin : stimulus
    int unsigned phase;
    int unsigned drawn;
    int unsigned kind;
    int unsigned major;
    int unsigned adv;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 8;
    recv_stall_pct = 49;

    push_advances(1);                        // advance with no line
    push_start(0, 0, 1023, 1023);            // full diagonal, y major
    push_advances(2);
    push_start(1023, 0, 0, 1023);            // replaces the line in progress
    push_advances(1);
    push_start(5, 5, 6, 5);                  // too short to draw
    push_advances(1);
    push_start(10, 20, 14, 22);              // shallow, runs past its end
    push_advances(5);
    push_start(100, 100, 98, 93);            // steep, both axes decreasing
    push_advances(2);
    settle();
    // change every register with the line still open
    write_reg(CfgFbBase, 32'hffff_fff0);
    write_reg(CfgFbWidth, 32'd1024);
    write_reg(CfgPixelDepth, 32'(Depth4));
    push_advances(2);
    settle();
    write_reg(CfgPixelDepth, 32'd0);
    push_advances(1);
    settle();
    write_reg(CfgPixelDepth, 32'd3);         // unsupported depth at start
    push_start(0, 0, 20, 3);
    push_advances(2);

    for (phase = 0; phase < 3; phase++) begin
      settle();
      case (phase)
        0: begin
          write_reg(CfgFbBase, 32'd0);
          write_reg(CfgFbWidth, 32'd1);
          write_reg(CfgPixelDepth, 32'(Depth8));
        end
        1: begin
          send_idle_pct = 49;
          recv_stall_pct = 8;
          write_reg(CfgFbBase, 32'hffff_ffff);
          write_reg(CfgFbWidth, 32'd1024);
          write_reg(CfgPixelDepth, 32'(Depth4));
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
          write_reg(CfgFbBase, $urandom);
          write_reg(CfgFbWidth, $urandom_range(1024, 1));
          write_reg(CfgPixelDepth, 32'(Depth2));
        end
      endcase
      drawn = 0;
      while (drawn < PhaseItems) begin
        kind = $urandom_range(19, 0);
        if (kind < 14) begin
          // whole line, sometimes followed by an advance past its end
          major = push_random_start(kind < 10 ? 12 : 40);
          adv = major + ($urandom_range(3, 0) == 0);
        end else if (kind < 17) begin
          major = push_random_start(20);
          adv = $urandom_range(major, 0);
        end else if (kind < 18) begin
          major = push_random_start(1023);
          adv = $urandom_range(24, 4);
        end else begin
          adv = $urandom_range(3, 0);
          line_reqs.push_back(random_req());
        end
        push_advances(adv);
        drawn += 1 + adv;
      end
    end

    settle();
    $display("Checked %0d pixel writes from %0d line requests across %0d register writes.",
             writes_checked, reqs_taken, reg_writes);
    $display("Covered short, steep, reversed and cut-off lines, idle advances, live depth changes.");
    if (mismatches == 0) begin
      $display("** packed_pixel_line_drawer: PASSED **");
    end else begin
      $display("** packed_pixel_line_drawer: FAILED **");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+sv
sv/ppld_pkg.sv
sv/ppld_walker.sv
sv/ppld_addr.sv
sv/packed_pixel_line_drawer.sv
tb/packed_pixel_line_drawer_test.sv
